>>> hw/rtl/otb_pkg.sv
// Shared types, constants and helpers for the one-shot timer bank.
package otb_pkg;

	localparam int SLOTS       = 16;
	localparam int COUNT_BITS  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int N_W         = $clog2(MAX_RESULTS + 1);

	typedef logic [COUNT_BITS-1:0] count_t;
	localparam count_t CNT_MAX = '1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_NOSPACE  = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EXPIRED  = 3'd4;
	localparam logic [2:0] ST_QUIET    = 3'd5;

	// Input beat kinds; the last one is taken and dropped.
	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_CANCEL,
		KIND_TICK,
		KIND_NONE
	} kind_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_ADD,
		OP_CANCEL,
		OP_TICK
	} op_t;

	// Walking request: travels one cell per cycle when not held and carries the result in hand.
	typedef struct packed {
		logic             vld;
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [5:0]       sid;
		count_t           cnt;
		logic [15:0]      tag;
		logic             pend_has;
		logic [2:0]       pend_st;
		logic [5:0]       pend_slot;
		logic [15:0]      pend_tag;
		logic [N_W-1:0]   n;
	} probe_t;

	typedef struct packed {
		logic        vld;
		logic [2:0]  st;
		logic [5:0]  slot;
		logic [15:0] tag;
	} res_t;

	function automatic count_t sat_count(input logic [15:0] secs);
		if (32'(secs) > 32'(CNT_MAX)) begin
			return CNT_MAX;
		end
		return COUNT_BITS'(secs);
	endfunction

endpackage

>>> hw/rtl/one_shot_timer_bank_top.sv
// Top level of the one-shot timer bank: request launch, cell chain and result register.
// Each accepted item launches a request that walks the chain of SLOTS timer cells, one cell
// per cycle while not held; in_ready rises again once the request leaves the last cell, so
// a new item is taken only after the last one is through, and the walk holds while the
// result register is full and waits on out_ready. Add and cancel give one result at
// the end of the walk; a tick gives each expiry as the walk passes the next expiring slot and
// the final one at the end, or one quiet result. Kind 3 is taken and dropped without a result.
module one_shot_timer_bank_top
	import otb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] seconds,
	input  logic [15:0] job_tag,
	input  logic [5:0]  slot_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [5:0]  slot,
	output logic [15:0] tag_out,
	output logic        last
);

	probe_t       chain [SLOTS+1];
	res_t         emits [SLOTS];
	probe_t       launch_q, seed, end_p;
	res_t         em, fin;
	logic         busy_q, out_valid_q, last_q, adv, accept;
	logic [2:0]   status_q;
	logic [5:0]   slot_q;
	logic [15:0]  tag_q;
	logic [SLOTS:0] pv;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign adv      = !out_valid_q || out_ready;

	always_comb begin
		seed      = '0;
		seed.vld  = 1'b1;
		seed.sid  = slot_id;
		seed.cnt  = sat_count(seconds);
		seed.tag  = job_tag;
		case (kind)
			KIND_ADD: begin
				seed.pend_has = 1'b1;
				if (seconds == '0) begin
					seed.op      = OP_NOP;
					seed.pend_st = ST_INVALID;
				end else begin
					seed.op      = OP_ADD;
					seed.pend_st = ST_NOSPACE;
				end
			end
			KIND_CANCEL: begin
				seed.op        = OP_CANCEL;
				seed.pend_has  = 1'b1;
				seed.pend_st   = ST_NOTFOUND;
				seed.pend_slot = slot_id;
			end
			KIND_TICK: begin
				seed.op = OP_TICK;
			end
			default: begin
				seed.vld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else if (accept) begin
			launch_q <= seed;
		end else if (adv) begin
			launch_q.vld <= 1'b0;
		end
	end

	assign chain[0] = launch_q;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		otb_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.p_in  (chain[g]),
			.p_out (chain[g+1]),
			.emit  (emits[g])
		);
	end

	assign end_p = chain[SLOTS];

	// only the cell holding the request can emit, so an OR picks it
	always_comb begin
		em = '0;
		for (int i = 0; i < SLOTS; i++) begin
			em = em | emits[i];
		end
	end

	always_comb begin
		fin = '0;
		fin.vld = end_p.vld;
		if (end_p.pend_has) begin
			fin.st   = end_p.pend_st;
			fin.slot = end_p.pend_slot;
			fin.tag  = end_p.pend_tag;
		end else begin
			fin.st = ST_QUIET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q      <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= em.vld || fin.vld;
			end
			if (accept && seed.vld) begin
				busy_q <= 1'b1;
			end else if (adv && end_p.vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && em.vld) begin
			status_q <= em.st;
			slot_q   <= em.slot;
			tag_q    <= em.tag;
			last_q   <= 1'b0;
		end else if (adv && fin.vld) begin
			status_q <= fin.st;
			slot_q   <= fin.slot;
			tag_q    <= fin.tag;
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign tag_out   = tag_q;
	assign last      = last_q;

	always_comb begin
		for (int i = 0; i <= SLOTS; i++) begin
			pv[i] = chain[i].vld;
		end
	end

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pv)) else $error("more than one request in the chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (pv == '0)) else $error("request in chain while idle");

	a_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(em.vld && end_p.vld)) else $error("expiry and final beat together");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && end_p.vld) |=> (out_valid && last && !busy_q))
		else $error("final beat not marked last");

endmodule

>>> hw/rtl/otb_cell.sv
// One timer slot: holds mode, count and tag, and acts on the passing request.
module otb_cell
	import otb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  probe_t p_in,
	output probe_t p_out,
	output res_t   emit
);

	typedef enum logic [1:0] {
		MODE_EMPTY,
		MODE_RUN,
		MODE_PAUSE,
		MODE_DONE
	} mode_t;

	mode_t       mode_q, mode_d;
	count_t      cnt_q, cnt_d;
	logic [15:0] tag_q;
	logic        tag_we;
	probe_t      probe_q, nxt;
	logic [5:0]  my_slot;

	assign my_slot = 6'(p_in.idx);

	always_comb begin
		nxt     = p_in;
		nxt.idx = p_in.idx + 1'b1;
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		tag_we  = 1'b0;
		emit    = '0;
		if (p_in.vld) begin
			case (p_in.op)
				OP_ADD: begin
					// take the first free slot while still unplaced
					if ((mode_q == MODE_EMPTY || mode_q == MODE_DONE) &&
					    p_in.pend_st == ST_NOSPACE) begin
						mode_d        = MODE_RUN;
						cnt_d         = p_in.cnt;
						tag_we        = 1'b1;
						nxt.pend_st   = ST_OK;
						nxt.pend_slot = my_slot;
					end
				end
				OP_CANCEL: begin
					if (my_slot == p_in.sid && mode_q != MODE_EMPTY) begin
						mode_d      = MODE_PAUSE;
						nxt.pend_st = ST_OK;
					end
				end
				OP_TICK: begin
					if (mode_q == MODE_RUN) begin
						if (cnt_q > count_t'(1)) begin
							cnt_d = cnt_q - 1'b1;
						end else if (p_in.n >= N_W'(MAX_RESULTS)) begin
							cnt_d = count_t'(1);
						end else begin
							cnt_d  = '0;
							mode_d = MODE_DONE;
							// release the held expiry; this one becomes the held one
							emit.vld      = p_in.pend_has;
							emit.st       = p_in.pend_st;
							emit.slot     = p_in.pend_slot;
							emit.tag      = p_in.pend_tag;
							nxt.pend_has  = 1'b1;
							nxt.pend_st   = ST_EXPIRED;
							nxt.pend_slot = my_slot;
							nxt.pend_tag  = tag_q;
							nxt.n         = p_in.n + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_EMPTY;
			cnt_q   <= '0;
			probe_q <= '0;
		end else if (adv) begin
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			probe_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tag_we) begin
			tag_q <= p_in.tag;
		end
	end

	assign p_out = probe_q;

endmodule

>>> test/tb.sv
// Self-checking testbench for the one-shot timer bank: directed and random beats, scoreboard.
`timescale 1ns / 100ps

module tb;
	import otb_pkg::*;

	typedef enum logic [1:0] {
		SLOT_FREE,
		SLOT_RUNNING,
		SLOT_PAUSED,
		SLOT_DONE
	} slot_mode_e;

	typedef struct {
		logic [2:0]  st;
		logic [5:0]  slot;
		logic [15:0] tag;
		logic        last;
	} bank_result_t;

	localparam int RANDOM_PER_PHASE = 80;
	localparam int MAX_PAUSED       = 6;
	localparam int HOLD_CYCLES      = 400;

	class timer_bank_scoreboard;
		slot_mode_e   mode[SLOTS];
		count_t       count_left[SLOTS];
		logic [15:0]  tag_held[SLOTS];
		bank_result_t due_results[$];
		bank_result_t burst[$];
		int           mismatches;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				mode[i]       = SLOT_FREE;
				count_left[i] = '0;
				tag_held[i]   = '0;
			end
			mismatches = 0;
		endfunction

		function void add_to_burst(logic [2:0] st, logic [5:0] sl, logic [15:0] tg);
			bank_result_t r;
			r.st   = st;
			r.slot = sl;
			r.tag  = tg;
			r.last = 1'b0;
			burst.push_back(r);
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		function int free_slots();
			int n;
			n = 0;
			for (int i = 0; i < SLOTS; i++)
				if (mode[i] == SLOT_FREE || mode[i] == SLOT_DONE) n++;
			return n;
		endfunction

		function int paused_slots();
			int n;
			n = 0;
			for (int i = 0; i < SLOTS; i++)
				if (mode[i] == SLOT_PAUSED) n++;
			return n;
		endfunction

		function bit occupied(logic [5:0] sid);
			if (sid >= SLOTS) return 1'b0;
			return mode[sid[IDX_W-1:0]] != SLOT_FREE;
		endfunction

		function void note_input(kind_t k, logic [15:0] secs, logic [15:0] tg, logic [5:0] sid);
			int found;
			burst.delete();
			case (k)
				KIND_ADD: begin
					found = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (found < 0 && (mode[i] == SLOT_FREE || mode[i] == SLOT_DONE))
							found = i;
					end
					if (secs == 16'd0) begin
						add_to_burst(ST_INVALID, 6'd0, 16'd0);
					end else if (found < 0) begin
						add_to_burst(ST_NOSPACE, 6'd0, 16'd0);
					end else begin
						count_left[found] = (32'(secs) > 32'(CNT_MAX)) ? CNT_MAX : count_t'(secs);
						tag_held[found]   = tg;
						mode[found]       = SLOT_RUNNING;
						add_to_burst(ST_OK, 6'(found), 16'd0);
					end
				end
				KIND_CANCEL: begin
					if (!occupied(sid)) begin
						add_to_burst(ST_NOTFOUND, sid, 16'd0);
					end else begin
						mode[sid[IDX_W-1:0]] = SLOT_PAUSED;
						add_to_burst(ST_OK, sid, 16'd0);
					end
				end
				KIND_TICK: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (mode[i] == SLOT_RUNNING) begin
							if (count_left[i] > 1) begin
								count_left[i] = count_left[i] - 1'b1;
							end else if (burst.size() >= MAX_RESULTS) begin
								// too many due at once: hold at one for the next tick
								count_left[i] = count_t'(1);
							end else begin
								count_left[i] = '0;
								mode[i]       = SLOT_DONE;
								add_to_burst(ST_EXPIRED, 6'(i), tag_held[i]);
							end
						end
					end
					if (burst.size() == 0) add_to_burst(ST_QUIET, 6'd0, 16'd0);
				end
				default: ;
			endcase
			if (burst.size() != 0) begin
				burst[burst.size() - 1].last = 1'b1;
				foreach (burst[i]) due_results.push_back(burst[i]);
			end
		endfunction

		function void check_result(logic [2:0] st, logic [5:0] sl, logic [15:0] tg, logic lst);
			bank_result_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d slot %0d tag %h last %b",
						st, sl, tg, lst);
				return;
			end
			want = due_results.pop_front();
			if (st !== want.st || sl !== want.slot || tg !== want.tag || lst !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected status %0d slot %0d tag %h last %b, ",
						"got status %0d slot %0d tag %h last %b"},
						want.st, want.slot, want.tag, want.last, st, sl, tg, lst);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [15:0] seconds;
	logic [15:0] job_tag;
	logic [5:0]  slot_id;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [5:0]  slot;
	logic [15:0] tag_out;
	logic        last;

	timer_bank_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;

	one_shot_timer_bank_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.seconds   (seconds),
		.job_tag   (job_tag),
		.slot_id   (slot_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.slot      (slot),
		.tag_out   (tag_out),
		.last      (last)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offer one beat, idling at random first, and note it once taken.
	task automatic send_beat(input kind_t k, input logic [15:0] secs, input logic [15:0] tg,
		input logic [5:0] sid);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		seconds  <= secs;
		job_tag  <= tg;
		slot_id  <= sid;
		do @(posedge clk); while (!in_ready);
		board.note_input(k, secs, tg, sid);
	endtask

	// Drop valid and hold until every expected beat has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	task automatic send_random_item(output bit counted);
		int          r;
		int          pick;
		logic [15:0] secs;
		logic [5:0]  sid;
		r       = $urandom_range(99);
		counted = 1'b1;
		if (r < 4) begin
			counted = 1'b0;
			send_beat(KIND_NONE, 16'($urandom), 16'($urandom), 6'($urandom));
		end else if (r < 40) begin
			send_beat(KIND_TICK, 16'($urandom), 16'($urandom), 6'($urandom));
		end else if (r < 85) begin
			pick = $urandom_range(99);
			if (pick < 5)
				secs = 16'd0;
			else if (pick < 8 && board.free_slots() > 8)
				secs = 16'($urandom_range(65535, 1000));
			else if (pick < 20)
				secs = 16'($urandom_range(40, 7));
			else
				secs = 16'($urandom_range(6, 1));
			send_beat(KIND_ADD, secs, 16'($urandom), 6'($urandom));
		end else begin
			sid = ($urandom_range(1) == 0) ? 6'($urandom_range(SLOTS - 1)) : 6'($urandom);
			// keep enough slots alive: paused ones never come back
			if (board.occupied(sid) && board.paused_slots() >= MAX_PAUSED)
				sid = 6'($urandom_range(63, SLOTS));
			send_beat(KIND_CANCEL, 16'($urandom), 16'($urandom), sid);
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				out_ready <= 1'b0;
				recv_hold--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (out_valid && out_ready) board.check_result(status, slot, tag_out, last);
		end
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		bit counted;
		int sent;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		kind     = KIND_ADD;
		seconds  = '0;
		job_tag  = '0;
		slot_id  = '0;
		recv_hold     = 0;
		send_idle_pct = 18;
		recv_idle_pct = 76;
		board = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_beat(KIND_TICK, 16'd0, 16'd0, 6'd0);
		send_beat(KIND_ADD, 16'd0, 16'h1234, 6'd0);
		send_beat(KIND_CANCEL, 16'd0, 16'd0, 6'd63);
		send_beat(KIND_CANCEL, 16'd0, 16'd0, 6'd5);
		// fill the bank with timers that all fall due on the same tick
		for (int i = 0; i < SLOTS; i++)
			send_beat(KIND_ADD, 16'd1,
				(i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom),
				(i == 0) ? 6'h3F : 6'(i));
		send_beat(KIND_ADD, 16'hFFFF, 16'hBEEF, 6'd0);
		send_beat(KIND_TICK, 16'd0, 16'd0, 6'd0);
		send_beat(KIND_CANCEL, 16'd0, 16'd0, 6'd0);
		send_beat(KIND_ADD, 16'hFFFF, 16'h5A5A, 6'd0);
		send_beat(KIND_CANCEL, 16'd0, 16'd0, 6'd1);
		send_beat(KIND_NONE, 16'hFFFF, 16'hFFFF, 6'h3F);
		drain_results();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 76 : 0;
			recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 18 : 0;
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				send_random_item(counted);
				if (counted) sent++;
				if (ph == 2 && sent == 30 && counted) recv_hold = HOLD_CYCLES;
				if (ph == 1 && sent == RANDOM_PER_PHASE / 2 && counted) drain_results();
			end
			drain_results();
		end

		repeat (SLOTS + 4) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/otb_pkg.sv
hw/rtl/otb_cell.sv
hw/rtl/one_shot_timer_bank_top.sv
test/tb.sv
